### rtl/core/jbpq_pkg.sv
// Shared types, constants and codes for the jitter buffer playout queue.
// Used by jbpq_ctrl, jbpq_dp and the top module; depends on nothing.
package jbpq_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;  // power of two
  localparam int unsigned DEPTH_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = DEPTH_W + 1;
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned US_PER_S    = 1000000;
  localparam int unsigned NUM_W       = 52;
  localparam int unsigned DIV_CNT_W   = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    CFG_TARGET = 2'd0,
    CFG_MAX    = 2'd1,
    CFG_FACTOR = 2'd2,
    CFG_RATE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_POPPED   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_EARLY    = 3'd4,
    ST_LATE     = 3'd5
  } status_e;

  localparam logic KIND_INSERT = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [47:0] arrival_us;
    logic [23:0] jitter_us;
    logic [31:0] media_stamp;
    logic [15:0] seq_number;
    logic [15:0] data_handle;
    logic [10:0] data_bytes;
    logic [47:0] now_us;
    logic [10:0] room_bytes;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [10:0] out_bytes;
    logic [15:0] out_seq;
    logic [31:0] out_stamp;
    logic [31:0] loss_total;
  } out_t;

  typedef struct packed {
    logic [47:0] play_time;
    logic [31:0] stamp;
    logic [15:0] seq;
    logic [15:0] handle;
    logic [10:0] bytes;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    mul;
    logic    dly;
    logic    sum;
    logic    scan;
    logic    shift;
    logic    ins;
    logic    pop_rd;
    logic    pop_chk;
    logic    div;
    logic    finish;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic in_kind;
    logic full;
    logic empty;
    logic scan_stop;
    logic shift_done;
    logic early;
    logic div_done;
    logic late;
    logic out_free;
  } sts_t;

endpackage

### rtl/core/jbpq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module jbpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/jbpq_ctrl.sv
// Sequencer for the playout queue: walks insert and playout requests through
// the datapath steps. Depends on jbpq_pkg.
module jbpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  jbpq_pkg::sts_t sts_i,
  output jbpq_pkg::cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_MUL     = 12'b000000000010,
    S_DLY     = 12'b000000000100,
    S_SUM     = 12'b000000001000,
    S_SCAN    = 12'b000000010000,
    S_SHIFT   = 12'b000000100000,
    S_INS     = 12'b000001000000,
    S_POP_RD  = 12'b000010000000,
    S_POP_CHK = 12'b000100000000,
    S_DIV     = 12'b001000000000,
    S_LATE    = 12'b010000000000,
    S_FINISH  = 12'b100000000000
  } state_e;

  state_e            state_q, state_d;
  jbpq_pkg::status_e status_q, status_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.status = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_kind == jbpq_pkg::KIND_INSERT) begin
            if (sts_i.full) begin
              status_d = jbpq_pkg::ST_FULL;
              state_d  = S_FINISH;
            end else begin
              state_d = S_MUL;
            end
          end else if (sts_i.empty) begin
            status_d = jbpq_pkg::ST_EMPTY;
            state_d  = S_FINISH;
          end else begin
            state_d = S_POP_RD;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DLY;
      end
      S_DLY: begin
        cmd_o.dly = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_stop) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        cmd_o.ins = 1'b1;
        status_d  = jbpq_pkg::ST_INSERTED;
        state_d   = S_FINISH;
      end
      S_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = S_POP_CHK;
      end
      S_POP_CHK: begin
        cmd_o.pop_chk = 1'b1;
        if (sts_i.early) begin
          status_d = jbpq_pkg::ST_EARLY;
          state_d  = S_FINISH;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_LATE;
        end
      end
      S_LATE: begin
        status_d = sts_i.late ? jbpq_pkg::ST_LATE : jbpq_pkg::ST_POPPED;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= jbpq_pkg::ST_INSERTED;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

### rtl/core/jbpq_dp.sv
// Datapath of the playout queue: entry RAM, ring pointers, play time math,
// lateness divider, loss counter and output register.
// Depends on jbpq_pkg and jbpq_ram.
module jbpq_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jbpq_pkg::cmd_t cmd_i,
  output jbpq_pkg::sts_t sts_o,
  input  jbpq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jbpq_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);

  localparam int unsigned DW = jbpq_pkg::DEPTH_W;
  localparam int unsigned CW = jbpq_pkg::CNT_W;
  localparam int unsigned NW = jbpq_pkg::NUM_W;

  logic [9:0]  tgt_q, max_q;
  logic [7:0]  fac_q;
  logic [15:0] rate_q;

  jbpq_pkg::in_t    item_q;
  jbpq_pkg::entry_t rd, wdata, hd_q;
  jbpq_pkg::out_t   out_q;

  logic [DW-1:0] head_q, raddr, waddr;
  logic [CW-1:0] fill_q, k_q, j_q, pos_q;
  logic          pend_q, we, out_valid_q;
  logic [31:0]   loss_q, loss_next;
  logic [31:0]   prod_q;
  logic [19:0]   delay_q, delay_d, base, cap;
  logic [28:0]   dsum;
  logic [47:0]   play_q;
  logic [NW-1:0] q_q, now_x;
  logic [15:0]   rem_q, rate_eff;
  logic [16:0]   trial;
  logic          trial_ge;
  logic [jbpq_pkg::DIV_CNT_W-1:0] dcnt_q;
  logic          hit, endk, fire, loss_inc;

  function automatic logic [DW-1:0] slot(input logic [DW-1:0] head, input logic [CW-1:0] off);
    return head + off[DW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q  <= 10'd40;
      max_q  <= 10'd100;
      fac_q  <= 8'd24;
      rate_q <= 16'd48000;
    end else if (cfg_we_i) begin
      case (jbpq_pkg::cfg_idx_e'(cfg_idx_i))
        jbpq_pkg::CFG_TARGET: tgt_q  <= cfg_data_i[9:0];
        jbpq_pkg::CFG_MAX:    max_q  <= cfg_data_i[9:0];
        jbpq_pkg::CFG_FACTOR: fac_q  <= cfg_data_i[7:0];
        jbpq_pkg::CFG_RATE:   rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // play time
  assign base = 20'(20'(tgt_q) * 20'(jbpq_pkg::US_PER_MS));
  assign cap  = 20'(20'(max_q) * 20'(jbpq_pkg::US_PER_MS));
  assign dsum = 29'(base) + 29'(prod_q[31:4]);

  always_comb begin
    if (item_q.jitter_us == '0) begin
      delay_d = base;
    end else if (dsum > 29'(cap)) begin
      delay_d = cap;
    end else begin
      delay_d = dsum[19:0];
    end
  end

  // scan and shift
  assign hit  = pend_q && (play_q < rd.play_time);
  assign endk = (k_q == fill_q);

  always_comb begin
    raddr = head_q;
    if (cmd_i.scan) begin
      raddr = slot(head_q, k_q);
    end else if (cmd_i.shift) begin
      raddr = slot(head_q, j_q - CW'(1));
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot(head_q, pos_q);
    wdata = rd;
    if (cmd_i.shift && pend_q) begin
      we    = 1'b1;
      waddr = slot(head_q, j_q + CW'(1));
    end else if (cmd_i.ins) begin
      we              = 1'b1;
      wdata.play_time = play_q;
      wdata.stamp     = item_q.media_stamp;
      wdata.seq       = item_q.seq_number;
      wdata.handle    = item_q.data_handle;
      wdata.bytes     = item_q.data_bytes;
    end
  end

  jbpq_ram #(
    .WIDTH ($bits(jbpq_pkg::entry_t)),
    .DEPTH (jbpq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  // lateness divider
  assign rate_eff = (rate_q == '0) ? 16'd1 : rate_q;
  assign trial    = {rem_q, q_q[NW-1]};
  assign trial_ge = trial >= {1'b0, rate_eff};
  assign now_x    = NW'(item_q.now_us);

  assign fire     = cmd_i.finish && (!out_valid_q || out_ready_i);
  assign loss_inc = (cmd_i.status == jbpq_pkg::ST_FULL) || (cmd_i.status == jbpq_pkg::ST_LATE);
  assign loss_next = (loss_inc && loss_q != '1) ? loss_q + 32'd1 : loss_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      prod_q <= 32'(item_q.jitter_us) * 32'(fac_q);
    end
    if (cmd_i.dly) begin
      delay_q <= delay_d;
    end
    if (cmd_i.sum) begin
      play_q <= item_q.arrival_us + 48'(delay_q);
    end
    if (cmd_i.pop_chk) begin
      hd_q  <= rd;
      q_q   <= NW'(rd.stamp) * NW'(jbpq_pkg::US_PER_S);
      rem_q <= '0;
    end else if (cmd_i.div && !sts_o.div_done) begin
      q_q   <= {q_q[NW-2:0], trial_ge};
      rem_q <= trial_ge ? 16'(trial - {1'b0, rate_eff}) : trial[15:0];
    end
    if (cmd_i.scan && hit) begin
      pos_q <= k_q - CW'(1);
    end else if (cmd_i.scan && endk) begin
      pos_q <= fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      loss_q      <= '0;
      k_q         <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sum) begin
        k_q    <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.scan) begin
        if (hit || endk) begin
          j_q    <= fill_q;
          pend_q <= 1'b0;
        end else begin
          k_q    <= k_q + CW'(1);
          pend_q <= 1'b1;
        end
      end else if (cmd_i.shift) begin
        if (j_q != pos_q) begin
          j_q    <= j_q - CW'(1);
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
      end
      if (cmd_i.pop_chk) begin
        dcnt_q <= '0;
      end else if (cmd_i.div && !sts_o.div_done) begin
        dcnt_q <= dcnt_q + jbpq_pkg::DIV_CNT_W'(1);
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        loss_q      <= loss_next;
        case (cmd_i.status)
          jbpq_pkg::ST_INSERTED: fill_q <= fill_q + CW'(1);
          jbpq_pkg::ST_POPPED, jbpq_pkg::ST_LATE: begin
            fill_q <= fill_q - CW'(1);
            head_q <= head_q + DW'(1);
          end
          default: ;
        endcase
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q            <= '0;
      out_q.status     <= cmd_i.status;
      out_q.loss_total <= loss_next;
      if (cmd_i.status == jbpq_pkg::ST_POPPED || cmd_i.status == jbpq_pkg::ST_LATE) begin
        out_q.out_seq   <= hd_q.seq;
        out_q.out_stamp <= hd_q.stamp;
      end
      if (cmd_i.status == jbpq_pkg::ST_POPPED) begin
        out_q.out_handle <= hd_q.handle;
        out_q.out_bytes  <= (hd_q.bytes < item_q.room_bytes) ? hd_q.bytes : item_q.room_bytes;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.in_kind    = in_data_i.kind;
  assign sts_o.full       = fill_q >= CW'(jbpq_pkg::QUEUE_DEPTH);
  assign sts_o.empty      = (fill_q == '0);
  assign sts_o.scan_stop  = hit || endk;
  assign sts_o.shift_done = !pend_q && (j_q == pos_q);
  assign sts_o.early      = item_q.now_us < rd.play_time;
  assign sts_o.div_done   = (dcnt_q == jbpq_pkg::DIV_CNT_W'(NW));
  assign sts_o.late       = (now_x > q_q) && ((now_x - q_q) > NW'(cap));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(jbpq_pkg::QUEUE_DEPTH))
    else $error("fill count above depth");

  a_loss_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 loss_q >= $past(loss_q))
    else $error("loss count went down");

  a_write_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (cmd_i.shift || cmd_i.ins))
    else $error("RAM write outside insert");

  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_i.status == jbpq_pkg::ST_POPPED) |=> fill_q == $past(fill_q) - CW'(1))
    else $error("pop did not release an entry");

endmodule

### rtl/core/jitter_buffer_playout_queue.sv
// Jitter buffer playout queue: up to 64 packets held in one RAM ring sorted
// by play time. One word at a time; the next word is taken once the current
// result sits in the output register. An insert scans the queued entries up to
// its place and shifts every entry behind it up by one slot; a rejected insert
// on a full queue skips both. A playout that pops or drops runs the lateness
// divider, which gives one quotient bit per cycle; an empty or too-early answer
// skips it. Any result waits while the output register is still held by the
// receiver.
// Depends on jbpq_pkg, jbpq_ctrl, jbpq_dp and jbpq_ram.
module jitter_buffer_playout_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jbpq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jbpq_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);

  jbpq_pkg::cmd_t cmd;
  jbpq_pkg::sts_t sts;

  jbpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jbpq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

### bench/jitter_buffer_playout_queue_test.sv
// Self-checking bench for the jitter buffer playout queue: random and directed
// insert/playout words, a built-in queue predictor, field-by-field result check.
// Depends on jbpq_pkg and the jitter_buffer_playout_queue RTL.
`timescale 1ns / 100ps
module jitter_buffer_playout_queue_test;

  localparam int unsigned DEPTH = jbpq_pkg::QUEUE_DEPTH;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  jbpq_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  jbpq_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  jitter_buffer_playout_queue dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // predictor state
  jbpq_pkg::entry_t ring [DEPTH];
  int unsigned head_slot, fill, n_losses;
  logic [9:0] target_ms, max_ms;
  logic [7:0] factor_q4;
  logic [15:0] rate_hz;

  jbpq_pkg::in_t pending_words[$];
  jbpq_pkg::out_t expected_results[$];
  int errors = 0, n_in = 0, n_out = 0, n_popped = 0, n_late = 0, n_full = 0;
  bit in_quiet = 0, out_quiet = 0;
  int hold_off = 0;

  // accept flag sampled at the rising edge
  logic in_ready_o_q = 1'b0;
  always @(posedge clk_i) in_ready_o_q <= in_valid_i && in_ready_o;

  function automatic void count_loss();
    if (n_losses != 32'hFFFF_FFFF) n_losses++;
  endfunction

  function automatic jbpq_pkg::out_t play_queue(jbpq_pkg::in_t w);
    jbpq_pkg::out_t r;
    logic [63:0] delay, cap, play, stamp_us, rate, limit;
    int unsigned pos, h;
    r = '0;
    if (w.kind == jbpq_pkg::KIND_INSERT) begin
      if (fill >= DEPTH) begin
        count_loss();
        r.status = jbpq_pkg::ST_FULL;
      end else begin
        delay = 64'(target_ms) * 1000;
        if (w.jitter_us != 0) begin
          cap = 64'(max_ms) * 1000;
          delay += (64'(w.jitter_us) * factor_q4) >> 4;
          if (delay > cap) delay = cap;
        end
        play = (64'(w.arrival_us) + delay) & 64'hFFFF_FFFF_FFFF;
        pos = fill;
        for (int k = 0; k < fill; k++)
          if (play[47:0] < ring[(head_slot + k) % DEPTH].play_time) begin
            pos = k;
            break;
          end
        for (int k = fill; k > pos; k--)
          ring[(head_slot + k) % DEPTH] = ring[(head_slot + k - 1) % DEPTH];
        ring[(head_slot + pos) % DEPTH] = '{play[47:0], w.media_stamp, w.seq_number,
                                            w.data_handle, w.data_bytes};
        fill++;
        r.status = jbpq_pkg::ST_INSERTED;
      end
    end else if (fill == 0) begin
      r.status = jbpq_pkg::ST_EMPTY;
    end else begin
      h = head_slot;
      if (w.now_us < ring[h].play_time) begin
        r.status = jbpq_pkg::ST_EARLY;
      end else begin
        rate = (rate_hz == 0) ? 1 : 64'(rate_hz);
        stamp_us = 64'(ring[h].stamp) * 1000000 / rate;
        limit = 64'(max_ms) * 1000;
        r.out_seq = ring[h].seq;
        r.out_stamp = ring[h].stamp;
        if (64'(w.now_us) > stamp_us && 64'(w.now_us) - stamp_us > limit) begin
          count_loss();
          r.status = jbpq_pkg::ST_LATE;
        end else begin
          r.status = jbpq_pkg::ST_POPPED;
          r.out_handle = ring[h].handle;
          r.out_bytes = (11'(ring[h].bytes) < w.room_bytes) ? ring[h].bytes : w.room_bytes;
        end
        head_slot = (h + 1) % DEPTH;
        fill--;
      end
    end
    r.loss_total = n_losses;
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o_q) begin
        expected_results.push_back(play_queue(in_data_i));
        n_in++;
      end
      if (!(in_valid_i && !in_ready_o_q)) begin
        if (pending_words.size() > 0 && (in_quiet || $urandom_range(99) >= 25)) begin
          in_data_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= out_quiet || $urandom_range(99) >= 25;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    jbpq_pkg::out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data_o.status == jbpq_pkg::ST_POPPED) n_popped++;
        if (out_data_o.status == jbpq_pkg::ST_LATE) n_late++;
        if (out_data_o.status == jbpq_pkg::ST_FULL) n_full++;
        if (out_data_o.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, out_data_o.status);
        if (out_data_o.out_handle !== exp_r.out_handle)
          $display("%0t: handle exp %h got %h", $realtime, exp_r.out_handle,
                   out_data_o.out_handle);
        if (out_data_o.out_bytes !== exp_r.out_bytes)
          $display("%0t: bytes exp %0d got %0d", $realtime, exp_r.out_bytes,
                   out_data_o.out_bytes);
        if (out_data_o.out_seq !== exp_r.out_seq)
          $display("%0t: seq exp %h got %h", $realtime, exp_r.out_seq, out_data_o.out_seq);
        if (out_data_o.out_stamp !== exp_r.out_stamp)
          $display("%0t: stamp exp %h got %h", $realtime, exp_r.out_stamp,
                   out_data_o.out_stamp);
        if (out_data_o.loss_total !== exp_r.loss_total)
          $display("%0t: loss exp %0d got %0d", $realtime, exp_r.loss_total,
                   out_data_o.loss_total);
        if (out_data_o !== exp_r) errors++;
      end
    end
  end

  function automatic jbpq_pkg::in_t make_insert(logic [47:0] arr, logic [23:0] jit,
                                                logic [31:0] stamp);
    jbpq_pkg::in_t w;
    w = '0;
    w.kind = jbpq_pkg::KIND_INSERT;
    w.arrival_us = arr;
    w.jitter_us = jit;
    w.media_stamp = stamp;
    w.seq_number = 16'($urandom);
    w.data_handle = 16'($urandom);
    w.data_bytes = 11'($urandom_range(1500));
    w.now_us = 48'({$urandom, $urandom});
    w.room_bytes = 11'($urandom);
    return w;
  endfunction

  function automatic jbpq_pkg::in_t make_playout(logic [47:0] now, logic [10:0] room);
    jbpq_pkg::in_t w;
    w = jbpq_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom});
    w.kind = ~jbpq_pkg::KIND_INSERT;
    w.now_us = now;
    w.room_bytes = room;
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(jbpq_pkg::cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      jbpq_pkg::CFG_TARGET: target_ms = val[9:0];
      jbpq_pkg::CFG_MAX: max_ms = val[9:0];
      jbpq_pkg::CFG_FACTOR: factor_q4 = val[7:0];
      default: rate_hz = val;
    endcase
  endtask

  // random traffic near a running clock so pops reach popped and late statuses
  task automatic random_phase(int n);
    logic [47:0] clock_us;
    logic [31:0] stamp;
    clock_us = 48'($urandom_range(1000, 100000)) * 1000;
    for (int i = 0; i < n; i++) begin
      clock_us += $urandom_range(5000);
      stamp = 32'((64'(clock_us) - $urandom_range(150000)) * (rate_hz == 0 ? 1 : rate_hz)
                  / 1000000);
      if ($urandom_range(9) == 0)
        pending_words.push_back(jbpq_pkg::in_t'({$urandom, $urandom, $urandom, $urandom,
                                                 $urandom, $urandom, $urandom}));
      else if ($urandom_range(1))
        pending_words.push_back(make_insert(clock_us, $urandom_range(1) ? 24'($urandom) :
                                            24'($urandom_range(50000)), stamp));
      else
        pending_words.push_back(make_playout(clock_us + $urandom_range(200000),
                                             11'($urandom)));
    end
  endtask

  initial begin
    head_slot = 0; fill = 0; n_losses = 0;
    target_ms = 40; max_ms = 100; factor_q4 = 24; rate_hz = 48000;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty, early, extremes, pop, late, equal play times
    pending_words.push_back(make_playout('0, '0));
    pending_words.push_back(make_insert('1, '1, '1));
    pending_words.push_back(make_playout('0, 11'h7FF));
    pending_words.push_back(make_playout('1, 11'h7FF));
    pending_words.push_back(make_insert(48'd1000, '0, 32'd48));
    pending_words.push_back(make_insert(48'd1000, '0, 32'd96));
    pending_words.push_back(make_insert(48'd0, 24'd1, 32'd0));
    pending_words.push_back(make_playout(48'd50000, 11'd0));
    pending_words.push_back(make_playout(48'd50000, 11'd2047));
    pending_words.push_back(make_playout(48'd50000, 11'd100));
    pending_words.push_back(make_playout(48'd50000, 11'd1));
    drain();

    write_reg(jbpq_pkg::CFG_TARGET, 16'd0);
    write_reg(jbpq_pkg::CFG_MAX, 16'd1023);
    write_reg(jbpq_pkg::CFG_FACTOR, 16'd255);
    write_reg(jbpq_pkg::CFG_RATE, 16'd8000);
    random_phase(150);
    drain();

    // fill past capacity with the receiver held off
    hold_off = 400;
    for (int i = 0; i < 70; i++)
      pending_words.push_back(make_insert(48'($urandom), 24'($urandom), $urandom));
    for (int i = 0; i < 70; i++)
      pending_words.push_back(make_playout('1, 11'($urandom)));
    drain();

    write_reg(jbpq_pkg::CFG_TARGET, 16'd1023);
    write_reg(jbpq_pkg::CFG_MAX, 16'd0);
    write_reg(jbpq_pkg::CFG_FACTOR, 16'd0);
    write_reg(jbpq_pkg::CFG_RATE, 16'd0);
    random_phase(60);
    drain();

    write_reg(jbpq_pkg::CFG_TARGET, 16'd40);
    write_reg(jbpq_pkg::CFG_MAX, 16'd200);
    write_reg(jbpq_pkg::CFG_FACTOR, 16'd24);
    write_reg(jbpq_pkg::CFG_RATE, 16'd48000);
    in_quiet = 1; out_quiet = 1;
    random_phase(60);
    drain();
    in_quiet = 0; out_quiet = 0;
    random_phase(150);
    drain();

    $display("Ran %0d words: %0d popped, %0d late drops, %0d full rejects.",
             n_in, n_popped, n_late, n_full);
    if (errors == 0 && expected_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
